### hw/rtl/ardec_pkg.sv
// Shared types, microcode table and shift table of the auxiliary bin decoder.
package ardec_pkg;

    localparam int PC_W = 4;

    typedef logic [PC_W-1:0] pc_t;

    typedef enum logic [3:0] {
        OP_BUMP,
        OP_TEST,
        OP_FIRST,
        OP_RENORM,
        OP_ZBYTE,
        OP_NORM,
        OP_COMMIT,
        OP_EARLY,
        OP_STARVE,
        OP_LOAD
    } op_t;

    typedef enum logic [1:0] {
        COND_NONE,
        COND_EARLY,
        COND_VAL_ZERO
    } cond_t;

    localparam pc_t PC_BUMP   = 4'd0;
    localparam pc_t PC_TEST   = 4'd1;
    localparam pc_t PC_FIRST  = 4'd2;
    localparam pc_t PC_RENORM = 4'd3;
    localparam pc_t PC_ZBYTE  = 4'd4;
    localparam pc_t PC_NORM   = 4'd5;
    localparam pc_t PC_COMMIT = 4'd6;
    localparam pc_t PC_EARLY  = 4'd7;
    localparam pc_t PC_STARVE = 4'd8;
    localparam pc_t PC_LOAD   = 4'd9;

    localparam logic [7:0]  RANGE_MAX    = 8'hff;
    localparam logic [7:0]  RANGE_RENORM = 8'hfe;
    localparam logic [10:0] VAL_BIAS     = 11'h100;
    localparam logic [7:0]  LIMIT_MAX    = 8'hff;
    localparam logic [3:0]  BYTE_BITS    = 4'd8;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        pc_t   target;
        logic  last;
    } uword_t;

    typedef struct packed {
        logic early;
        logic val_zero;
        logic short_win;
    } stat_t;

    typedef struct packed {
        logic       flag;
        logic [6:0] bits_used;
        logic       starved;
    } res_t;

    function automatic uword_t ucode(pc_t pc);
        uword_t w;
        unique case (pc)
            PC_BUMP:   w = '{OP_BUMP,   COND_NONE,     PC_BUMP,   1'b0};
            PC_TEST:   w = '{OP_TEST,   COND_EARLY,    PC_EARLY,  1'b0};
            PC_FIRST:  w = '{OP_FIRST,  COND_NONE,     PC_FIRST,  1'b0};
            PC_RENORM: w = '{OP_RENORM, COND_NONE,     PC_RENORM, 1'b0};
            PC_ZBYTE:  w = '{OP_ZBYTE,  COND_VAL_ZERO, PC_ZBYTE,  1'b0};
            PC_NORM:   w = '{OP_NORM,   COND_NONE,     PC_NORM,   1'b0};
            PC_COMMIT: w = '{OP_COMMIT, COND_NONE,     PC_COMMIT, 1'b1};
            PC_EARLY:  w = '{OP_EARLY,  COND_NONE,     PC_EARLY,  1'b1};
            PC_STARVE: w = '{OP_STARVE, COND_NONE,     PC_STARVE, 1'b1};
            PC_LOAD:   w = '{OP_LOAD,   COND_NONE,     PC_LOAD,   1'b1};
            default:   w = '{OP_STARVE, COND_NONE,     PC_STARVE, 1'b1};
        endcase
        return w;
    endfunction

    function automatic logic [3:0] nib_shift(logic [3:0] n);
        logic [3:0] s;
        case (n)
            4'd0:            s = 4'd0;
            4'd1:            s = 4'd4;
            4'd2, 4'd3:      s = 4'd3;
            4'd4, 4'd5,
            4'd6, 4'd7:      s = 4'd2;
            default:         s = 4'd1;
        endcase
        return s;
    endfunction

    function automatic logic [3:0] norm_shift(logic [7:0] v);
        logic [3:0] s;
        if (v[7:4] == 4'd0) begin
            s = nib_shift(v[3:0]) + 4'd4;
        end else begin
            s = nib_shift(v[7:4]);
        end
        return s;
    endfunction

endpackage

### hw/rtl/ardec_seq.sv
// Microcode sequencer: step counter, control word fetch and conditional jumps.
module ardec_seq (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic              start_load,
    input  logic              en,
    input  ardec_pkg::stat_t  stat,
    output ardec_pkg::uword_t uword,
    output logic              busy
);
    import ardec_pkg::*;

    pc_t  pc_reg, pc_next;
    logic busy_reg, busy_next;
    logic jump;

    assign uword = ucode(pc_reg);
    assign busy  = busy_reg;

    always_comb begin
        pc_next   = pc_reg;
        busy_next = busy_reg;
        jump      = 1'b0;
        case (uword.cond)
            COND_EARLY:    jump = stat.early;
            COND_VAL_ZERO: jump = stat.val_zero;
            default:       jump = 1'b0;
        endcase
        if (start) begin
            pc_next   = start_load ? PC_LOAD : PC_BUMP;
            busy_next = 1'b1;
        end else if (busy_reg && en) begin
            if (uword.last) begin
                busy_next = 1'b0;
            end else if (stat.short_win) begin
                pc_next = PC_STARVE;
            end else if (jump) begin
                pc_next = uword.target;
            end else begin
                pc_next = pc_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg   <= PC_BUMP;
            busy_reg <= 1'b0;
        end else begin
            pc_reg   <= pc_next;
            busy_reg <= busy_next;
        end
    end

endmodule

### hw/rtl/ardec_dp.sv
// Datapath: engine state, working registers and stream bit window.
module ardec_dp #(
    parameter int WINDOW_BITS = 64
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic             run,
    input  ardec_pkg::op_t   op,
    input  logic             s_cmd,
    input  logic [63:0]      s_bit_window,
    input  logic [7:0]       s_load_range,
    input  logic [7:0]       s_load_value,
    input  logic [7:0]       s_load_low_count,
    input  logic [7:0]       s_load_limit,
    output ardec_pkg::stat_t stat,
    output ardec_pkg::res_t  res
);
    import ardec_pkg::*;

    localparam int POS_W = $clog2(WINDOW_BITS + 1);

    logic [7:0]             range_reg, value_reg, low_reg, limit_reg;
    logic [7:0]             rng_reg, rng_next;
    logic [10:0]            val_reg, val_next;
    logic [7:0]             lo_reg, lo_next;
    logic [7:0]             lim_reg, lim_next;
    logic [WINDOW_BITS-1:0] win_reg, win_next;
    logic [POS_W-1:0]       pos_reg, pos_next;

    logic [3:0]   take_n;
    logic         need_take;
    logic [7:0]   peek, take_bits;
    logic [POS_W:0] pos_sum;
    logic         eq, early, val_zero, short_win;
    logic [3:0]   sh;
    logic [8:0]   lim_sum;
    logic [3:0]   lim_add;

    assign eq        = lo_reg == limit_reg;
    assign early     = (lo_reg < limit_reg) || (eq && (val_reg < {3'b000, rng_reg}));
    assign val_zero  = val_reg == 11'd0;
    assign sh        = norm_shift(val_reg[7:0]);
    assign peek      = win_reg[WINDOW_BITS-1 -: 8];
    assign take_bits = peek >> (BYTE_BITS - take_n);
    assign pos_sum   = (POS_W + 1)'(pos_reg) + (POS_W + 1)'(take_n);
    assign short_win = need_take && (pos_sum > (POS_W + 1)'(WINDOW_BITS));
    assign lim_sum   = 9'(lim_reg) + 9'(lim_add);

    assign stat.early     = early;
    assign stat.val_zero  = val_zero;
    assign stat.short_win = short_win;

    assign res.flag      = op == OP_COMMIT;
    assign res.bits_used = (op == OP_COMMIT) ? 7'(pos_reg) : 7'd0;
    assign res.starved   = op == OP_STARVE;

    always_comb begin
        need_take = 1'b0;
        take_n    = 4'd0;
        lim_add   = 4'd0;
        rng_next  = rng_reg;
        val_next  = val_reg;
        lo_next   = lo_reg;
        unique case (op)
            OP_BUMP: begin
                if (rng_reg < RANGE_MAX) begin
                    rng_next = rng_reg + 8'd1;
                    lo_next  = lo_reg + 8'd1;
                end else begin
                    rng_next = 8'd0;
                end
            end
            OP_FIRST: begin
                if (eq) begin
                    val_next = val_reg - 11'(rng_reg);
                end else begin
                    need_take = 1'b1;
                    take_n    = 4'd1;
                    val_next  = ((val_reg << 1) | 11'(take_bits[0])) - 11'(rng_reg) + VAL_BIAS;
                end
            end
            OP_RENORM: begin
                if (rng_reg <= 8'd1) begin
                    need_take = 1'b1;
                    take_n    = 4'd1;
                    val_next  = (val_reg << 1) | 11'(take_bits[0]);
                    rng_next  = RANGE_RENORM;
                end else begin
                    rng_next = rng_reg - 8'd2;
                end
            end
            OP_ZBYTE: begin
                if (val_zero) begin
                    need_take = 1'b1;
                    take_n    = BYTE_BITS;
                    lim_add   = BYTE_BITS;
                    val_next  = 11'(take_bits);
                end
            end
            OP_NORM: begin
                if (val_reg < VAL_BIAS) begin
                    need_take = 1'b1;
                    take_n    = sh;
                    lim_add   = sh;
                    val_next  = (val_reg << sh) | 11'(take_bits);
                end
            end
            default: begin
            end
        endcase
        lim_next = lim_sum[8] ? LIMIT_MAX : lim_sum[7:0];
        win_next = win_reg << take_n;
        pos_next = pos_reg + POS_W'(take_n);
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            win_reg <= s_bit_window[63 -: WINDOW_BITS];
            pos_reg <= '0;
            rng_reg <= range_reg;
            val_reg <= {3'b000, value_reg};
            lo_reg  <= low_reg;
            lim_reg <= 8'd0;
        end else if (run && !short_win) begin
            win_reg <= win_next;
            pos_reg <= pos_next;
            rng_reg <= rng_next;
            val_reg <= val_next;
            lo_reg  <= lo_next;
            lim_reg <= lim_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            range_reg <= 8'd0;
            value_reg <= 8'd0;
            low_reg   <= 8'd0;
            limit_reg <= 8'd0;
        end else if (start && s_cmd) begin
            range_reg <= s_load_range;
            value_reg <= s_load_value;
            low_reg   <= s_load_low_count;
            limit_reg <= s_load_limit;
        end else if (run && op == OP_COMMIT) begin
            range_reg <= rng_reg;
            value_reg <= val_reg[7:0];
            low_reg   <= 8'd0;
            limit_reg <= lim_reg;
        end else if (run && op == OP_EARLY) begin
            range_reg <= rng_reg;
            low_reg   <= lo_reg;
        end
    end

endmodule

### hw/rtl/arith_decoder_aux_bin_step_core.sv
// Auxiliary bin decode engine: top level with handshakes and result register.
//
// Each transfer on the s_ channel is one command. A load command (s_cmd = 1)
// writes range, value and both counters and returns an all-zero result. A
// decode command runs a short microprogram, one step per clock (the last step
// waits while an earlier result is held), on the engine state and the first
// WINDOW_BITS bits of s_bit_window, and returns the flag, the bits consumed
// and a starvation mark (state left unchanged). A load runs only the LOAD
// step; a decode runs BUMP and TEST, then the early flag-0 exit EARLY or
// FIRST, RENORM, ZBYTE (repeated while the value is zero, one byte each),
// NORM and COMMIT; a step that runs out of bits leads to STARVE. The next
// command is taken in the cycle after the last step. The sequencer sets the
// steps, one control word per cycle with the same stall. The result sits in
// an output register: a new command is taken while the prior result waits on m_ready.
module arith_decoder_aux_bin_step_core #(
    parameter int WINDOW_BITS = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_cmd,
    input  logic [63:0] s_bit_window,
    input  logic [7:0]  s_load_range,
    input  logic [7:0]  s_load_value,
    input  logic [7:0]  s_load_low_count,
    input  logic [7:0]  s_load_limit,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_flag,
    output logic [6:0]  m_bits_used,
    output logic        m_starved
);
    import ardec_pkg::*;

    uword_t uword;
    stat_t  stat;
    res_t   res;
    logic   busy, start, en, run;
    logic   m_valid_reg, m_valid_next;
    res_t   res_reg;

    assign s_ready = !busy;
    assign start   = s_valid && s_ready;
    assign en      = !(uword.last && m_valid_reg && !m_ready);
    assign run     = busy && en;

    ardec_seq u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (start),
        .start_load (s_cmd),
        .en         (en),
        .stat       (stat),
        .uword      (uword),
        .busy       (busy)
    );

    ardec_dp #(
        .WINDOW_BITS (WINDOW_BITS)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .start            (start),
        .run              (run),
        .op               (uword.op),
        .s_cmd            (s_cmd),
        .s_bit_window     (s_bit_window),
        .s_load_range     (s_load_range),
        .s_load_value     (s_load_value),
        .s_load_low_count (s_load_low_count),
        .s_load_limit     (s_load_limit),
        .stat             (stat),
        .res              (res)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (run && uword.last) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // hold the result until its transfer
    always_ff @(posedge aclk) begin
        if (run && uword.last) begin
            res_reg <= res;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_flag      = res_reg.flag;
    assign m_bits_used = res_reg.bits_used;
    assign m_starved   = res_reg.starved;

endmodule
